/* src/drcls_pkg.sv */
// Package for the receive-buffer cache line splitter.
// Holds the field widths, register indexes and the structs passed between the
// pipeline stages. No dependencies.
`default_nettype none

package drcls_pkg;

  // Field widths of the work items.
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned LEN_W    = 24;
  localparam int unsigned IDX_W    = 2;
  localparam int unsigned MAX_DESC = 3;

  // Stream widths, padded to whole bytes.
  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned OUT_TDATA_W = 168;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEAD_BOUNCE = 1'b0,
    CFG_TAIL_BOUNCE = 1'b1
  } cfg_reg_e;

  // Stage 1 result: the buffer, its end address and its first aligned line.
  typedef struct packed {
    logic [ADDR_W-1:0] buf_addr;
    logic [LEN_W-1:0]  buf_len;
    logic [ADDR_W-1:0] end_addr;
    logic [ADDR_W-1:0] first_line;
  } addr_t;

  // Stage 2 result: the whole descriptor chain of one buffer.
  typedef struct packed {
    logic [IDX_W-1:0]                 num_desc;
    logic [MAX_DESC-1:0][ADDR_W-1:0]  target;
    logic [MAX_DESC-1:0][LEN_W-1:0]   count;
    logic [LEN_W-1:0]                 head_len;
    logic [LEN_W-1:0]                 tail_len;
    logic [ADDR_W-1:0]                inv_addr;
    logic [LEN_W-1:0]                 inv_len;
  } plan_t;

  // One emitted descriptor.
  typedef struct packed {
    logic [IDX_W-1:0]  desc_index;
    logic [ADDR_W-1:0] target_addr;
    logic [LEN_W-1:0]  byte_count;
    logic              chain_next;
    logic              last_desc;
    logic [LEN_W-1:0]  head_copy_len;
    logic [LEN_W-1:0]  tail_copy_len;
    logic [ADDR_W-1:0] invalidate_addr;
    logic [LEN_W-1:0]  invalidate_len;
  } desc_t;

endpackage

`default_nettype wire

/* src/drcls_addr_stage.sv */
// First pipeline stage of the splitter: registers the buffer and computes
// its end address and first aligned line address.
// Depends on drcls_pkg.
`default_nettype none

module drcls_addr_stage #(
  parameter int unsigned LINE_BYTES = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          valid_i,
  output logic                               ready_o,
  input  wire logic [drcls_pkg::ADDR_W-1:0]  buffer_addr_i,
  input  wire logic [drcls_pkg::LEN_W-1:0]   byte_length_i,
  output logic                               valid_o,
  input  wire logic                          ready_i,
  output drcls_pkg::addr_t                   addr_o
);

  localparam logic [drcls_pkg::ADDR_W-1:0] LineMask = drcls_pkg::ADDR_W'(LINE_BYTES - 1);

  logic             valid_q;
  drcls_pkg::addr_t addr_q, addr_d;

  // The stage takes a new transaction when empty or when its content moves on.
  assign ready_o = !valid_q || ready_i;

  // End address and round-up to the next line boundary, both modulo 2^32.
  always_comb begin
    addr_d.buf_addr   = buffer_addr_i;
    addr_d.buf_len    = byte_length_i;
    addr_d.end_addr   = buffer_addr_i + drcls_pkg::ADDR_W'(byte_length_i);
    addr_d.first_line = (buffer_addr_i + LineMask) & ~LineMask;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      addr_q <= addr_d;
    end
  end

  assign valid_o = valid_q;
  assign addr_o  = addr_q;

endmodule

`default_nettype wire

/* src/drcls_plan_stage.sv */
// Second pipeline stage of the splitter: derives head, middle and tail
// lengths and decides the descriptor chain of one buffer.
// Depends on drcls_pkg.
`default_nettype none

module drcls_plan_stage #(
  parameter int unsigned LINE_BYTES = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          valid_i,
  output logic                               ready_o,
  input  drcls_pkg::addr_t                   addr_i,
  input  wire logic [drcls_pkg::ADDR_W-1:0]  head_bounce_i,
  input  wire logic [drcls_pkg::ADDR_W-1:0]  tail_bounce_i,
  output logic                               valid_o,
  input  wire logic                          ready_i,
  output drcls_pkg::plan_t                   plan_o
);

  localparam logic [drcls_pkg::ADDR_W-1:0] LineMask = drcls_pkg::ADDR_W'(LINE_BYTES - 1);
  localparam logic [drcls_pkg::LEN_W-1:0]  LineLen  = drcls_pkg::LEN_W'(LINE_BYTES);

  logic                          valid_q;
  drcls_pkg::plan_t              plan_q, plan_d;
  logic [drcls_pkg::ADDR_W-1:0]  last_line;
  logic [drcls_pkg::ADDR_W-1:0]  head_full;
  logic [drcls_pkg::ADDR_W-1:0]  mid_full;
  logic [drcls_pkg::LEN_W-1:0]   head_len;
  logic [drcls_pkg::LEN_W-1:0]   tail_len;
  logic [drcls_pkg::LEN_W-1:0]   mid_len;
  logic                          is_short;
  logic                          start_aligned;
  logic                          tail_empty;

  assign ready_o = !valid_q || ready_i;

  // Lengths of the three parts of the buffer.
  always_comb begin
    last_line     = addr_i.end_addr & ~LineMask;
    head_full     = addr_i.first_line - addr_i.buf_addr;
    mid_full      = last_line - addr_i.first_line;
    head_len      = head_full[drcls_pkg::LEN_W-1:0];
    mid_len       = mid_full[drcls_pkg::LEN_W-1:0];
    tail_len      = drcls_pkg::LEN_W'(addr_i.end_addr & LineMask);
    is_short      = addr_i.buf_len < LineLen;
    start_aligned = (addr_i.buf_addr & LineMask) == '0;
    tail_empty    = tail_len == '0;
  end

  // Chain decision.
  always_comb begin
    plan_d           = '0;
    plan_d.head_len  = head_len;
    plan_d.tail_len  = tail_len;
    plan_d.inv_addr  = addr_i.first_line;
    plan_d.inv_len   = mid_len;
    if (is_short) begin
      // Whole buffer into the head bounce buffer, nothing to invalidate.
      plan_d.num_desc  = 2'd1;
      plan_d.target[0] = head_bounce_i;
      plan_d.count[0]  = addr_i.buf_len;
      plan_d.head_len  = addr_i.buf_len;
      plan_d.tail_len  = '0;
      plan_d.inv_addr  = '0;
      plan_d.inv_len   = '0;
    end else if (start_aligned && tail_empty) begin
      plan_d.num_desc  = 2'd1;
      plan_d.target[0] = addr_i.first_line;
      plan_d.count[0]  = addr_i.buf_len;
    end else if (start_aligned) begin
      plan_d.num_desc  = 2'd2;
      plan_d.target[0] = addr_i.first_line;
      plan_d.count[0]  = mid_len;
      plan_d.target[1] = tail_bounce_i;
      plan_d.count[1]  = tail_len;
    end else if (tail_empty) begin
      plan_d.num_desc  = 2'd2;
      plan_d.target[0] = head_bounce_i;
      plan_d.count[0]  = head_len;
      plan_d.target[1] = addr_i.first_line;
      plan_d.count[1]  = mid_len;
    end else if (mid_len == '0) begin
      // Unaligned at both ends with no whole line in between.
      plan_d.num_desc  = 2'd1;
      plan_d.target[0] = head_bounce_i;
      plan_d.count[0]  = addr_i.buf_len;
      plan_d.head_len  = addr_i.buf_len;
      plan_d.tail_len  = '0;
      plan_d.inv_len   = '0;
    end else begin
      plan_d.num_desc  = 2'd3;
      plan_d.target[0] = head_bounce_i;
      plan_d.count[0]  = head_len;
      plan_d.target[1] = addr_i.first_line;
      plan_d.count[1]  = mid_len;
      plan_d.target[2] = tail_bounce_i;
      plan_d.count[2]  = tail_len;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      plan_q <= plan_d;
    end
  end

  assign valid_o = valid_q;
  assign plan_o  = plan_q;

endmodule

`default_nettype wire

/* src/drcls_emit.sv */
// Last pipeline stage of the splitter: holds one descriptor chain and sends
// its descriptors one per cycle while the receiver does not stall, through a registered output.
// Depends on drcls_pkg.
`default_nettype none

module drcls_emit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  output logic            ready_o,
  input  drcls_pkg::plan_t plan_i,
  output logic            valid_o,
  input  wire logic       ready_i,
  output drcls_pkg::desc_t desc_o
);

  logic                          plan_vld_q;
  drcls_pkg::plan_t              plan_q;
  logic [drcls_pkg::IDX_W-1:0]   idx_q;
  logic                          out_vld_q;
  drcls_pkg::desc_t              out_q, out_d;
  logic                          out_free;
  logic                          issue;
  logic                          last_issue;
  logic [drcls_pkg::IDX_W-1:0]   last_idx;

  // A held chain issues a descriptor whenever the output is free or drains.
  assign out_free   = !out_vld_q || ready_i;
  assign last_idx   = plan_q.num_desc - 2'd1;
  assign issue      = plan_vld_q && out_free;
  assign last_issue = issue && (idx_q == last_idx);
  assign ready_o    = !plan_vld_q || last_issue;

  // Select the current descriptor of the held chain.
  always_comb begin
    out_d                 = '0;
    out_d.desc_index      = idx_q;
    out_d.chain_next      = idx_q != last_idx;
    out_d.last_desc       = idx_q == last_idx;
    out_d.head_copy_len   = plan_q.head_len;
    out_d.tail_copy_len   = plan_q.tail_len;
    out_d.invalidate_addr = plan_q.inv_addr;
    out_d.invalidate_len  = plan_q.inv_len;
    case (idx_q)
      2'd0: begin
        out_d.target_addr = plan_q.target[0];
        out_d.byte_count  = plan_q.count[0];
      end
      2'd1: begin
        out_d.target_addr = plan_q.target[1];
        out_d.byte_count  = plan_q.count[1];
      end
      default: begin
        out_d.target_addr = plan_q.target[2];
        out_d.byte_count  = plan_q.count[2];
      end
    endcase
  end

  // Chain holder and descriptor counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plan_vld_q <= 1'b0;
      idx_q      <= '0;
    end else if (ready_o) begin
      plan_vld_q <= valid_i;
      idx_q      <= '0;
    end else if (issue) begin
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      plan_q <= plan_i;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      out_q <= out_d;
    end
  end

  assign valid_o = out_vld_q;
  assign desc_o  = out_q;

  // A held chain always has at least one descriptor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    plan_vld_q |-> plan_q.num_desc != 2'd0)
    else $error("held descriptor chain is empty");

  // The descriptor counter stays inside the held chain.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    plan_vld_q |-> idx_q <= last_idx)
    else $error("descriptor counter ran past the chain");

  // The chain flag and the last flag are exclusive on every output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_q.chain_next != out_q.last_desc))
    else $error("chain and last flags disagree");

  // Issuing the final descriptor shows a last descriptor in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_issue |=> (out_vld_q && out_q.last_desc))
    else $error("final descriptor not marked last");

endmodule

`default_nettype wire

/* src/dma_rx_cache_line_split_unit.sv */
// Receive-buffer cache line splitter, top level.
// Usage:
//   Each transaction on the s_axis channel carries a receive buffer address
//   and length. The block answers with one to three chained DMA descriptors
//   on the m_axis channel, in chain order, the final one marked by tlast.
//   Only whole cache lines are written directly; the unaligned head and tail
//   go to the head and tail bounce buffers set through the cfg channel.
//   The cfg channel is always ready; write it only while the block is idle.
// Timing:
//   The first descriptor of a buffer passes the address stage, plan stage,
//   chain holder and output register in turn before it shows on m_axis.
//   While m_axis_tready stays high the emit stage sends one descriptor per
//   cycle, holding each buffer until its last descriptor is issued; a new
//   buffer is accepted in every cycle while single-descriptor buffers flow.
// Reset and stall:
//   Reset empties the pipeline and sets both bounce addresses to zero.
//   When the receiver holds tready low the output register keeps its
//   descriptor and the stages behind it fill up and then drop s_axis_tready.
// Depends on drcls_pkg, drcls_addr_stage, drcls_plan_stage and drcls_emit.
`default_nettype none

module dma_rx_cache_line_split_unit #(
  parameter int unsigned LINE_BYTES = 32
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // Buffer input: [31:0] buffer_addr, [55:32] byte_length.
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  input  wire logic [drcls_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // Descriptor output: [1:0] desc_index, [33:2] target_addr,
  // [57:34] byte_count, [58] chain_next, [82:59] head_copy_len,
  // [106:83] tail_copy_len, [138:107] invalidate_addr,
  // [162:139] invalidate_len, [167:163] zero.
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  output logic [drcls_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
  output logic                                      m_axis_tlast,
  // Configuration write channel.
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [drcls_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [drcls_pkg::ADDR_W-1:0]         cfg_data_i
);

  logic [drcls_pkg::ADDR_W-1:0] head_bounce_q;
  logic [drcls_pkg::ADDR_W-1:0] tail_bounce_q;
  logic                         addr_vld;
  logic                         plan_rdy;
  drcls_pkg::addr_t             addr;
  logic                         plan_vld;
  logic                         emit_rdy;
  drcls_pkg::plan_t             plan;
  drcls_pkg::desc_t             desc;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_bounce_q <= '0;
      tail_bounce_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (drcls_pkg::cfg_reg_e'(cfg_index_i))
        drcls_pkg::CFG_HEAD_BOUNCE: head_bounce_q <= cfg_data_i;
        drcls_pkg::CFG_TAIL_BOUNCE: tail_bounce_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  drcls_addr_stage #(
    .LINE_BYTES (LINE_BYTES)
  ) u_addr_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (s_axis_tvalid),
    .ready_o       (s_axis_tready),
    .buffer_addr_i (s_axis_tdata[31:0]),
    .byte_length_i (s_axis_tdata[55:32]),
    .valid_o       (addr_vld),
    .ready_i       (plan_rdy),
    .addr_o        (addr)
  );

  drcls_plan_stage #(
    .LINE_BYTES (LINE_BYTES)
  ) u_plan_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (addr_vld),
    .ready_o       (plan_rdy),
    .addr_i        (addr),
    .head_bounce_i (head_bounce_q),
    .tail_bounce_i (tail_bounce_q),
    .valid_o       (plan_vld),
    .ready_i       (emit_rdy),
    .plan_o        (plan)
  );

  drcls_emit u_emit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (plan_vld),
    .ready_o (emit_rdy),
    .plan_i  (plan),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .desc_o  (desc)
  );

  // Pack the descriptor onto the output stream.
  assign m_axis_tdata = {5'b0,
                         desc.invalidate_len,
                         desc.invalidate_addr,
                         desc.tail_copy_len,
                         desc.head_copy_len,
                         desc.chain_next,
                         desc.byte_count,
                         desc.target_addr,
                         desc.desc_index};
  assign m_axis_tlast = desc.last_desc;

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// Testbench for the receive-buffer cache line splitter.
// It drives buffer transactions and bounce address writes, then checks each descriptor
// against the predicted split. Depends on drcls_pkg and the top level.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned LINE_BYTES   = 32;
  localparam int unsigned PIPE_DEPTH   = 4;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned NUM_DIRECTED = 18;
  localparam int unsigned NUM_PHASES   = 4;
  localparam int unsigned PHASE_ITEMS  = 33;

  // One directed buffer, with an optional hand-written expected descriptor.
  typedef struct packed {
    logic [drcls_pkg::ADDR_W-1:0] addr;
    logic [drcls_pkg::LEN_W-1:0]  len;
    logic                         typed;
    drcls_pkg::desc_t             want;
  } buffer_row_t;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready;
  logic [drcls_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  logic [drcls_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                              m_axis_tlast;
  logic                              cfg_valid_i = 1'b0;
  logic                              cfg_ready_o;
  drcls_pkg::cfg_reg_e               cfg_index_i = drcls_pkg::CFG_HEAD_BOUNCE;
  logic [drcls_pkg::ADDR_W-1:0]      cfg_data_i = '0;

  // Bounce addresses as the block should currently hold them.
  logic [drcls_pkg::ADDR_W-1:0] bounce_head = '0;
  logic [drcls_pkg::ADDR_W-1:0] bounce_tail = '0;

  drcls_pkg::desc_t pending_descs[$];
  drcls_pkg::desc_t next_desc;
  buffer_row_t      directed_rows [NUM_DIRECTED];
  int               fail_count = 0;
  bit               calm = 1'b0;

  dma_rx_cache_line_split_unit #(
    .LINE_BYTES(LINE_BYTES)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // 100 MHz clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Queue one expected descriptor.
  function automatic void queue_desc(input int unsigned idx,
                                     input logic [drcls_pkg::ADDR_W-1:0] target,
                                     input logic [31:0] count, input logic chain,
                                     input logic last, input logic [31:0] head_len,
                                     input logic [31:0] tail_len,
                                     input logic [drcls_pkg::ADDR_W-1:0] inv_addr,
                                     input logic [31:0] inv_len);
    drcls_pkg::desc_t d;
    d.desc_index      = drcls_pkg::IDX_W'(idx);
    d.target_addr     = target;
    d.byte_count      = count[drcls_pkg::LEN_W-1:0];
    d.chain_next      = chain;
    d.last_desc       = last;
    d.head_copy_len   = head_len[drcls_pkg::LEN_W-1:0];
    d.tail_copy_len   = tail_len[drcls_pkg::LEN_W-1:0];
    d.invalidate_addr = inv_addr;
    d.invalidate_len  = inv_len[drcls_pkg::LEN_W-1:0];
    pending_descs.push_back(d);
  endfunction

  // Split one buffer into its descriptor chain. All address arithmetic wraps at 2^32.
  function automatic void split_buffer(input logic [drcls_pkg::ADDR_W-1:0] buf_addr,
                                       input logic [drcls_pkg::LEN_W-1:0] buf_len);
    logic [31:0] line_mask, end_addr, first_line, last_line;
    logic [31:0] head_len, tail_len, mid_len, len32;
    line_mask  = LINE_BYTES - 1;
    len32      = {8'd0, buf_len};
    end_addr   = buf_addr + len32;
    first_line = (buf_addr + line_mask) & ~line_mask;
    last_line  = end_addr & ~line_mask;
    head_len   = first_line - buf_addr;
    tail_len   = end_addr & line_mask;
    mid_len    = last_line - first_line;
    if (len32 <= line_mask) begin
      // Shorter than a line: everything lands in the head bounce buffer.
      queue_desc(0, bounce_head, len32, 1'b0, 1'b1, len32, 0, '0, 0);
    end else if ((buf_addr & line_mask) == 0) begin
      if (tail_len == 0) begin
        queue_desc(0, first_line, len32, 1'b0, 1'b1, head_len, tail_len, first_line, mid_len);
      end else begin
        queue_desc(0, first_line, mid_len, 1'b1, 1'b0, head_len, tail_len, first_line, mid_len);
        queue_desc(1, bounce_tail, tail_len, 1'b0, 1'b1, head_len, tail_len, first_line,
                   mid_len);
      end
    end else if (tail_len == 0) begin
      queue_desc(0, bounce_head, head_len, 1'b1, 1'b0, head_len, tail_len, first_line, mid_len);
      queue_desc(1, first_line, mid_len, 1'b0, 1'b1, head_len, tail_len, first_line, mid_len);
    end else if (mid_len == 0) begin
      // Unaligned at both ends with no whole line in between.
      queue_desc(0, bounce_head, len32, 1'b0, 1'b1, len32, 0, first_line, 0);
    end else begin
      queue_desc(0, bounce_head, head_len, 1'b1, 1'b0, head_len, tail_len, first_line, mid_len);
      queue_desc(1, first_line, mid_len, 1'b1, 1'b0, head_len, tail_len, first_line, mid_len);
      queue_desc(2, bounce_tail, tail_len, 0, 1'b1, head_len, tail_len, first_line, mid_len);
    end
  endfunction

  // Offer one buffer transaction, occasionally after a drop of tvalid unless calm is set. Entered and
  // left at a falling edge; tvalid stays high so that back-to-back buffers flow.
  task automatic push_buffer(input logic [drcls_pkg::ADDR_W-1:0] addr,
                             input logic [drcls_pkg::LEN_W-1:0] len,
                             input logic typed, input drcls_pkg::desc_t want);
    if (!calm && $urandom_range(0, 99) < 9) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {len, addr};
    do @(posedge clk_i); while (!s_axis_tready);
    if (typed) pending_descs.push_back(want);
    else split_buffer(addr, len);
    @(negedge clk_i);
  endtask

  // Pick a buffer shape that reaches every branch of the split.
  task automatic push_random_buffer();
    logic [drcls_pkg::ADDR_W-1:0] addr;
    logic [drcls_pkg::LEN_W-1:0]  len;
    int unsigned                  shape;
    addr  = $urandom();
    shape = $urandom_range(0, 3);
    if (shape == 0) addr = addr & ~(LINE_BYTES - 1);
    else if (shape == 1) addr[31:8] = '1;
    shape = $urandom_range(0, 99);
    if (shape < 30) begin
      len = drcls_pkg::LEN_W'($urandom_range(0, LINE_BYTES - 1));
    end else if (shape < 45) begin
      len = drcls_pkg::LEN_W'($urandom_range(LINE_BYTES, 2 * LINE_BYTES - 2));
    end else if (shape < 65) begin
      // End the buffer exactly on a line boundary.
      len = drcls_pkg::LEN_W'($urandom_range(1, 20) * LINE_BYTES
                              + (LINE_BYTES - addr % LINE_BYTES) % LINE_BYTES);
    end else if (shape < 92) begin
      len = drcls_pkg::LEN_W'($urandom_range(LINE_BYTES, 1024));
    end else begin
      len = drcls_pkg::LEN_W'($urandom());
    end
    push_buffer(addr, len, 1'b0, '0);
  endtask

  // Stop sending and wait until every expected descriptor has arrived.
  task automatic wait_chain_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_descs.size() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH) @(negedge clk_i);
  endtask

  // Write both bounce addresses; the block must be idle.
  task automatic write_bounce_pair(input logic [drcls_pkg::ADDR_W-1:0] head_addr,
                                   input logic [drcls_pkg::ADDR_W-1:0] tail_addr);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= drcls_pkg::CFG_HEAD_BOUNCE;
    cfg_data_i  <= head_addr;
    do @(posedge clk_i); while (!cfg_ready_o);
    bounce_head = head_addr;
    @(negedge clk_i);
    cfg_index_i <= drcls_pkg::CFG_TAIL_BOUNCE;
    cfg_data_i  <= tail_addr;
    do @(posedge clk_i); while (!cfg_ready_o);
    bounce_tail = tail_addr;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      fail_count++;
    end
  endtask

  // Receiver backpressure.
  always @(negedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= 9);
  end

  // Compare each descriptor transaction with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_descs.size() == 0) begin
        $error("unexpected descriptor, tdata %h", m_axis_tdata);
        fail_count++;
      end else begin
        next_desc = pending_descs.pop_front();
        check_field("desc_index", next_desc.desc_index, m_axis_tdata[1:0]);
        check_field("target_addr", next_desc.target_addr, m_axis_tdata[33:2]);
        check_field("byte_count", next_desc.byte_count, m_axis_tdata[57:34]);
        check_field("chain_next", next_desc.chain_next, m_axis_tdata[58]);
        check_field("last_desc", next_desc.last_desc, m_axis_tlast);
        check_field("head_copy_len", next_desc.head_copy_len, m_axis_tdata[82:59]);
        check_field("tail_copy_len", next_desc.tail_copy_len, m_axis_tdata[106:83]);
        check_field("invalidate_addr", next_desc.invalidate_addr, m_axis_tdata[138:107]);
        check_field("invalidate_len", next_desc.invalidate_len, m_axis_tdata[162:139]);
        check_field("tdata padding", '0, m_axis_tdata[167:163]);
      end
    end
  end

  // End the run if no transaction of any kind moves for too long.
  initial begin : watchdog
    int unsigned stalled_cycles;
    stalled_cycles = 0;
    while (stalled_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
          || (cfg_valid_i && cfg_ready_o)) begin
        stalled_cycles = 0;
      end else begin
        stalled_cycles++;
      end
    end
    $display("testbench failed");
    $finish;
  end

  // Main sequence: directed buffers at reset settings, then random phases.
  initial begin
    // Rows with a typed descriptor assume both bounce addresses still at reset.
    directed_rows = '{
      // Empty buffer.
      '{32'h0000_0000, 24'h00_0000, 1'b1,
        '{2'd0, 32'h0, 24'h0, 1'b0, 1'b1, 24'h0, 24'h0, 32'h0, 24'h0}},
      // Longest short buffer at the top address.
      '{32'hFFFF_FFFF, 24'h00_001F, 1'b1,
        '{2'd0, 32'h0, 24'h1F, 1'b0, 1'b1, 24'h1F, 24'h0, 32'h0, 24'h0}},
      // Exactly one aligned line.
      '{32'h0000_0000, 24'h00_0020, 1'b1,
        '{2'd0, 32'h0, 24'h20, 1'b0, 1'b1, 24'h0, 24'h0, 32'h0, 24'h20}},
      '{32'h0000_0021, 24'h00_001F, 1'b1,
        '{2'd0, 32'h0, 24'h1F, 1'b0, 1'b1, 24'h1F, 24'h0, 32'h0, 24'h0}},
      '{32'h0000_0100, 24'h00_0040, 1'b0, '0},
      '{32'h0000_0200, 24'h00_0045, 1'b0, '0},
      '{32'h0000_0305, 24'h00_003B, 1'b0, '0},
      // Unaligned starts: two buffers with no whole line, then a three-part split and one with an aligned end.
      '{32'h0000_0401, 24'h00_0030, 1'b0, '0},
      '{32'h0000_001F, 24'h00_0020, 1'b0, '0},
      '{32'h0000_0501, 24'h00_0080, 1'b0, '0},
      '{32'h0000_001F, 24'h00_0021, 1'b0, '0},
      // Buffers that reach or wrap past the top of the address space, then long buffers.
      '{32'hFFFF_FFF0, 24'h00_0040, 1'b0, '0},
      '{32'hFFFF_FFE0, 24'h00_0020, 1'b0, '0},
      '{32'hFFFF_FFE0, 24'h00_0040, 1'b0, '0},
      '{32'h0000_0000, 24'hFF_FFFF, 1'b0, '0},
      '{32'hFFFF_FFE1, 24'hFF_FFFF, 1'b0, '0},
      '{32'hAAAA_AAAA, 24'h55_5555, 1'b0, '0},
      '{32'h5555_5555, 24'hAA_AAAA, 1'b0, '0}
    };
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[r]) begin
      push_buffer(directed_rows[r].addr, directed_rows[r].len, directed_rows[r].typed,
                  directed_rows[r].want);
    end
    wait_chain_drained();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: write_bounce_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        1: write_bounce_pair($urandom(), $urandom());
        2: write_bounce_pair(32'hFFFF_FFE0, 32'h0000_0000);
        default: write_bounce_pair(32'h0000_0020, $urandom());
      endcase
      // One whole phase runs with neither side idling.
      calm = (phase == 1);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (phase == 2 && k == PHASE_ITEMS / 2) wait_chain_drained();
        push_random_buffer();
      end
      wait_chain_drained();
    end

    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
